// ===== rtl/cls_pkg.sv =====
// Shared types, codes and constants for the CBOR log-list schema checker.
package cls_pkg;

	localparam int LEN_W = 31;
	localparam int ADDR_SIZE_DEF = 20;
	localparam int TOPIC_SIZE_DEF = 32;
	localparam logic [LEN_W-1:0] LOG_FIELDS = 31'd3;

	// Item header kinds from the upstream token decoder
	typedef enum logic [1:0] {
		REQ_ARRAY   = 2'd0,
		REQ_BYTES   = 2'd1,
		REQ_OTHER   = 2'd2,
		REQ_DEC_ERR = 2'd3
	} req_kind_t;

	// Parser position within the log list
	typedef enum logic [2:0] {
		MODE_LOGS   = 3'd0,
		MODE_LOG    = 3'd1,
		MODE_ADDR   = 3'd2,
		MODE_TOPICS = 3'd3,
		MODE_TOPIC  = 3'd4,
		MODE_DATA   = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_LOG_COUNT   = 3'd1,
		EV_ADDRESS     = 3'd2,
		EV_TOPIC_COUNT = 3'd3,
		EV_TOPIC       = 3'd4,
		EV_DATA        = 3'd5
	} event_kind_t;

	typedef enum logic [3:0] {
		ERR_OK              = 4'd0,
		ERR_BAD_TYPE        = 4'd1,
		ERR_DECODER         = 4'd2,
		ERR_ADDRESS_SIZE    = 4'd3,
		ERR_TOPIC_SIZE      = 4'd4,
		ERR_FIELD_COUNT     = 4'd5,
		ERR_BYTES_MISPLACED = 4'd6,
		ERR_ARRAY_MISPLACED = 4'd7,
		ERR_EARLIER         = 4'd8
	} err_code_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [LEN_W-1:0] item_length;
	} req_t;

	typedef struct packed {
		logic [2:0]       event_kind;
		logic [LEN_W-1:0] count_value;
		logic             last_topic;
		logic             last_log;
		logic [3:0]       error_code;
	} rsp_t;

endpackage

// ===== rtl/cbor_log_schema_checker.sv =====
// Top level: request register, schema check, result register.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_stall      cls_pkg::req_t
//   result    out        result_valid / result_stall  cls_pkg::rsp_t
//
// One request per cycle sustained while the result side is not stalled; each
// result passes through the request register, then the result register.
// The mode and counters update in the same edge that loads the result register.
// Reset clears the mode, counters, failure flag and both valid flags.
// A stalled result holds; item_stall rises only when the request register is
// full and the result register cannot move.
module cbor_log_schema_checker #(
	parameter int ADDR_SIZE  = cls_pkg::ADDR_SIZE_DEF,
	parameter int TOPIC_SIZE = cls_pkg::TOPIC_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  cls_pkg::req_t item,
	output logic          result_valid,
	input  logic          result_stall,
	output cls_pkg::rsp_t result
);

	logic          valid_s1;
	cls_pkg::req_t req_s1;
	logic          valid_s2;
	cls_pkg::rsp_t rsp_s2;
	cls_pkg::rsp_t rsp;
	logic          out_free;
	logic          step;
	logic          take;

	// Pipeline flow control
	assign out_free   = !valid_s2 || !result_stall;
	assign step       = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign take       = item_valid && !item_stall;

	cls_check #(
		.ADDR_SIZE (ADDR_SIZE),
		.TOPIC_SIZE(TOPIC_SIZE)
	) u_check (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.req   (req_s1),
		.rsp   (rsp)
	);

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) valid_s1 <= 1'b1;
			else if (step) valid_s1 <= 1'b0;
			if (step) valid_s2 <= 1'b1;
			else if (!result_stall) valid_s2 <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (take) req_s1 <= item;
		if (step) rsp_s2 <= rsp;
	end

	assign result_valid = valid_s2;
	assign result       = rsp_s2;

	// Stall on the request side only with a full request register
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && valid_s2)
		else $error("request stalled with room in pipeline");

	// A taken request reaches the result register the next time it can move
	a_step_fills: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("result register not loaded");

endmodule

// ===== rtl/cls_check.sv =====
// Schema state machine: mode, log and topic counters, sticky failure flag.
module cls_check #(
	parameter int ADDR_SIZE  = cls_pkg::ADDR_SIZE_DEF,
	parameter int TOPIC_SIZE = cls_pkg::TOPIC_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  cls_pkg::req_t req,
	output cls_pkg::rsp_t rsp
);

	localparam logic [cls_pkg::LEN_W-1:0] ADDR_LEN  = cls_pkg::LEN_W'(ADDR_SIZE);
	localparam logic [cls_pkg::LEN_W-1:0] TOPIC_LEN = cls_pkg::LEN_W'(TOPIC_SIZE);

	cls_pkg::mode_t             mode_q, mode_d;
	logic [cls_pkg::LEN_W-1:0]  logs_declared_q, logs_declared_d;
	logic [cls_pkg::LEN_W-1:0]  logs_seen_q, logs_seen_d;
	logic [cls_pkg::LEN_W-1:0]  topics_declared_q, topics_declared_d;
	logic [cls_pkg::LEN_W-1:0]  topics_seen_q, topics_seen_d;
	logic                       failed_q, failed_d;

	logic [cls_pkg::LEN_W-1:0]  topics_inc;
	logic [cls_pkg::LEN_W-1:0]  logs_inc;
	logic                       topic_last;
	logic                       log_last;
	cls_pkg::req_kind_t         kind;
	cls_pkg::err_code_t         err;

	// Counters wrap at the field width
	assign topics_inc = topics_seen_q + 1'b1;
	assign logs_inc   = logs_seen_q + 1'b1;
	assign topic_last = (topics_inc == topics_declared_q);
	assign log_last   = (logs_inc == logs_declared_q);
	assign kind       = cls_pkg::req_kind_t'(req.req_type);

	// Error classification for the current request
	always_comb begin
		err = cls_pkg::ERR_OK;
		if (failed_q) begin
			err = cls_pkg::ERR_EARLIER;
		end else begin
			unique case (kind)
				cls_pkg::REQ_OTHER:   err = cls_pkg::ERR_BAD_TYPE;
				cls_pkg::REQ_DEC_ERR: err = cls_pkg::ERR_DECODER;
				cls_pkg::REQ_BYTES: begin
					unique case (mode_q)
						cls_pkg::MODE_ADDR:
							if (req.item_length != ADDR_LEN) err = cls_pkg::ERR_ADDRESS_SIZE;
						cls_pkg::MODE_TOPIC:
							if (req.item_length != TOPIC_LEN) err = cls_pkg::ERR_TOPIC_SIZE;
						cls_pkg::MODE_DATA: err = cls_pkg::ERR_OK;
						default: err = cls_pkg::ERR_BYTES_MISPLACED;
					endcase
				end
				cls_pkg::REQ_ARRAY: begin
					unique case (mode_q)
						cls_pkg::MODE_LOGS, cls_pkg::MODE_TOPICS: err = cls_pkg::ERR_OK;
						cls_pkg::MODE_LOG:
							if (req.item_length != cls_pkg::LOG_FIELDS)
								err = cls_pkg::ERR_FIELD_COUNT;
						default: err = cls_pkg::ERR_ARRAY_MISPLACED;
					endcase
				end
				default: err = cls_pkg::ERR_BAD_TYPE;
			endcase
		end
	end

	// Next state
	always_comb begin
		mode_d            = mode_q;
		logs_declared_d   = logs_declared_q;
		logs_seen_d       = logs_seen_q;
		topics_declared_d = topics_declared_q;
		topics_seen_d     = topics_seen_q;
		failed_d          = failed_q;
		if (err != cls_pkg::ERR_OK) begin
			failed_d = 1'b1;
		end else if (kind == cls_pkg::REQ_BYTES) begin
			unique case (mode_q)
				cls_pkg::MODE_ADDR: mode_d = cls_pkg::MODE_TOPICS;
				cls_pkg::MODE_TOPIC: begin
					topics_seen_d = topics_inc;
					if (topic_last) mode_d = cls_pkg::MODE_DATA;
				end
				cls_pkg::MODE_DATA: begin
					logs_seen_d = logs_inc;
					mode_d = log_last ? cls_pkg::MODE_LOGS : cls_pkg::MODE_LOG;
				end
				default: mode_d = mode_q;
			endcase
		end else begin
			unique case (mode_q)
				cls_pkg::MODE_LOGS: begin
					logs_declared_d = req.item_length;
					logs_seen_d     = '0;
					mode_d          = cls_pkg::MODE_LOG;
				end
				cls_pkg::MODE_LOG: mode_d = cls_pkg::MODE_ADDR;
				cls_pkg::MODE_TOPICS: begin
					topics_declared_d = req.item_length;
					topics_seen_d     = '0;
					mode_d = (req.item_length == '0) ? cls_pkg::MODE_DATA : cls_pkg::MODE_TOPIC;
				end
				default: mode_d = mode_q;
			endcase
		end
	end

	// Result fields
	always_comb begin
		rsp.event_kind  = cls_pkg::EV_NONE;
		rsp.count_value = '0;
		rsp.last_topic  = 1'b0;
		rsp.last_log    = 1'b0;
		rsp.error_code  = err;
		if (err == cls_pkg::ERR_OK) begin
			rsp.count_value = req.item_length;
			if (kind == cls_pkg::REQ_BYTES) begin
				unique case (mode_q)
					cls_pkg::MODE_ADDR: rsp.event_kind = cls_pkg::EV_ADDRESS;
					cls_pkg::MODE_TOPIC: begin
						rsp.event_kind = cls_pkg::EV_TOPIC;
						rsp.last_topic = topic_last;
					end
					cls_pkg::MODE_DATA: begin
						rsp.event_kind = cls_pkg::EV_DATA;
						rsp.last_log   = log_last;
					end
					default: rsp.event_kind = cls_pkg::EV_NONE;
				endcase
			end else begin
				unique case (mode_q)
					cls_pkg::MODE_LOGS:   rsp.event_kind = cls_pkg::EV_LOG_COUNT;
					cls_pkg::MODE_TOPICS: rsp.event_kind = cls_pkg::EV_TOPIC_COUNT;
					default:              rsp.event_kind = cls_pkg::EV_NONE;
				endcase
			end
		end
	end

	// State registers, updated once per request that moves to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q            <= cls_pkg::MODE_LOGS;
			logs_declared_q   <= '0;
			logs_seen_q       <= '0;
			topics_declared_q <= '0;
			topics_seen_q     <= '0;
			failed_q          <= 1'b0;
		end else if (step) begin
			mode_q            <= mode_d;
			logs_declared_q   <= logs_declared_d;
			logs_seen_q       <= logs_seen_d;
			topics_declared_q <= topics_declared_d;
			topics_seen_q     <= topics_seen_d;
			failed_q          <= failed_d;
		end
	end

	// Failure is sticky until reset
	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |=> failed_q)
		else $error("failure flag cleared without reset");

	// Once failed, every request reports an earlier failure
	a_failed_reports: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |-> rsp.error_code == cls_pkg::ERR_EARLIER)
		else $error("failed checker did not report earlier failure");

	// An error result carries no event, count or marks
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.error_code != cls_pkg::ERR_OK |->
			rsp.event_kind == cls_pkg::EV_NONE && rsp.count_value == '0 &&
			!rsp.last_topic && !rsp.last_log)
		else $error("error result carries payload");

	// While waiting for topics, the list is never already complete
	a_topic_open: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == cls_pkg::MODE_TOPIC |-> topics_seen_q != topics_declared_q)
		else $error("topic mode with complete topic list");

endmodule

// ===== tb/cls_log_checker.sv =====
// Result checker for the CBOR log-list schema checker: watches both channels and compares.
module cls_log_checker
	import cls_pkg::*;
#(
	parameter int ADDR_SIZE  = ADDR_SIZE_DEF,
	parameter int TOPIC_SIZE = TOPIC_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  logic item_stall,
	input  req_t item,
	input  logic result_valid,
	input  logic result_stall,
	input  rsp_t result,
	output int   failures,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [LEN_W-1:0] ADDR_LEN  = LEN_W'(ADDR_SIZE);
	localparam logic [LEN_W-1:0] TOPIC_LEN = LEN_W'(TOPIC_SIZE);

	// Shadow of the parser state
	mode_t            pos;
	logic [LEN_W-1:0] logs_total;
	logic [LEN_W-1:0] logs_done;
	logic [LEN_W-1:0] topics_total;
	logic [LEN_W-1:0] topics_done;
	logic             broken;

	rsp_t expected_results[$];
	int   mismatches = 0;

	assign failures = mismatches;

	task automatic report_mismatch(input string msg);
		$display("%0t ns  checker: %s", $realtime, msg);
		mismatches++;
	endtask

	// Advance the shadow parser by one request and return the answer it gives
	function automatic rsp_t schema_step(input req_t r);
		rsp_t             o;
		logic [LEN_W-1:0] n;
		logic             last;
		o = '0;
		n = r.item_length;
		if (broken) begin
			o.error_code = ERR_EARLIER;
			return o;
		end
		case (r.req_type)
			REQ_OTHER: o.error_code = ERR_BAD_TYPE;
			REQ_DEC_ERR: o.error_code = ERR_DECODER;
			REQ_BYTES: begin
				case (pos)
					MODE_ADDR: begin
						if (n != ADDR_LEN) begin
							o.error_code = ERR_ADDRESS_SIZE;
						end else begin
							pos = MODE_TOPICS;
							o.event_kind = EV_ADDRESS;
							o.count_value = n;
						end
					end
					MODE_TOPIC: begin
						if (n != TOPIC_LEN) begin
							o.error_code = ERR_TOPIC_SIZE;
						end else begin
							topics_done = topics_done + 1'b1;
							last = (topics_done == topics_total);
							if (last)
								pos = MODE_DATA;
							o.event_kind = EV_TOPIC;
							o.count_value = n;
							o.last_topic = last;
						end
					end
					MODE_DATA: begin
						logs_done = logs_done + 1'b1;
						last = (logs_done == logs_total);
						pos = last ? MODE_LOGS : MODE_LOG;
						o.event_kind = EV_DATA;
						o.count_value = n;
						o.last_log = last;
					end
					default: o.error_code = ERR_BYTES_MISPLACED;
				endcase
			end
			default: begin
				// array header
				case (pos)
					MODE_LOGS: begin
						logs_total = n;
						logs_done = '0;
						pos = MODE_LOG;
						o.event_kind = EV_LOG_COUNT;
						o.count_value = n;
					end
					MODE_LOG: begin
						// a good log header carries no event, only its count
						if (n != LOG_FIELDS) begin
							o.error_code = ERR_FIELD_COUNT;
						end else begin
							pos = MODE_ADDR;
							o.count_value = n;
						end
					end
					MODE_TOPICS: begin
						topics_total = n;
						topics_done = '0;
						pos = (n == '0) ? MODE_DATA : MODE_TOPIC;
						o.event_kind = EV_TOPIC_COUNT;
						o.count_value = n;
					end
					default: o.error_code = ERR_ARRAY_MISPLACED;
				endcase
			end
		endcase
		if (o.error_code != ERR_OK)
			broken = 1'b1;
		return o;
	endfunction

	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result %h", got));
			return;
		end
		want = expected_results.pop_front();
		if (got.event_kind !== want.event_kind)
			report_mismatch($sformatf("event_kind %0d, expected %0d",
				got.event_kind, want.event_kind));
		if (got.count_value !== want.count_value)
			report_mismatch($sformatf("count_value %0d, expected %0d",
				got.count_value, want.count_value));
		if (got.last_topic !== want.last_topic)
			report_mismatch($sformatf("last_topic %0b, expected %0b",
				got.last_topic, want.last_topic));
		if (got.last_log !== want.last_log)
			report_mismatch($sformatf("last_log %0b, expected %0b",
				got.last_log, want.last_log));
		if (got.error_code !== want.error_code)
			report_mismatch($sformatf("error_code %0d, expected %0d",
				got.error_code, want.error_code));
	endtask

	// Sample both handshakes on the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos = MODE_LOGS;
			logs_total = '0;
			logs_done = '0;
			topics_total = '0;
			topics_done = '0;
			broken = 1'b0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (result_valid && !result_stall)
				check_result(result);
			if (item_valid && !item_stall)
				expected_results.push_back(schema_step(item));
			pending <= expected_results.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the bench: clock, reset, request stimulus, result stalls and the verdict.
module testbench;
	import cls_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [LEN_W-1:0] ADDR_LEN  = LEN_W'(ADDR_SIZE_DEF);
	localparam logic [LEN_W-1:0] TOPIC_LEN = LEN_W'(TOPIC_SIZE_DEF);
	localparam int RANDOM_ITEMS = 1590;
	localparam int PHASE_ITEMS  = 200;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	req_t item;
	logic result_valid;
	logic result_stall;
	rsp_t result;
	int   fail_count;
	int   pending;

	int idle_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;

	cbor_log_schema_checker u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	cls_log_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.failures    (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit, far beyond the slowest legal run
	initial begin
		#(12ns * 400000);
		$display("testbench: FAIL");
		$finish;
	end

	// Result side back-pressure
	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	function automatic logic [LEN_W-1:0] rand_len();
		logic [31:0] r;
		r = $urandom;
		return r[LEN_W-1:0];
	endfunction

	// Data lengths: a quarter up to 64, a quarter up to 65535, half spread over all bits
	function automatic logic [LEN_W-1:0] data_len();
		case ($urandom_range(0, 3))
			0: return LEN_W'($urandom_range(0, 64));
			1: return LEN_W'($urandom_range(0, 65535));
			default: return rand_len();
		endcase
	endfunction

	// A byte string length that misses the required one
	function automatic logic [LEN_W-1:0] off_size(input logic [LEN_W-1:0] right);
		logic [LEN_W-1:0] n;
		case ($urandom_range(0, 3))
			0: n = '0;
			1: n = right - 1'b1;
			2: n = right + 1'b1;
			default: n = rand_len();
		endcase
		if (n == right)
			n = n + 1'b1;
		return n;
	endfunction

	// Offer one request, with random idle cycles first, and wait until it is taken
	task automatic send_item(input req_kind_t kind, input logic [LEN_W-1:0] len);
		req_t r;
		r.req_type = kind;
		r.item_length = len;
		while ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= r;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_log(input int topics, input logic [LEN_W-1:0] data);
		send_item(REQ_ARRAY, LOG_FIELDS);
		send_item(REQ_BYTES, ADDR_LEN);
		send_item(REQ_ARRAY, LEN_W'(topics));
		repeat (topics)
			send_item(REQ_BYTES, TOPIC_LEN);
		send_item(REQ_BYTES, data);
	endtask

	// Hold off new requests until every outstanding result is back
	task automatic drain();
		item_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// A failure is sticky until reset, so the schema is only broken at the very end.
	// The log list may be left open at any point first.
	task automatic finish_with_violation();
		mode_t            stop;
		logic [LEN_W-1:0] n;
		int               k;
		stop = mode_t'($urandom_range(0, 5));
		if (stop != MODE_LOGS) begin
			// a log list that never closes: empty or at the largest count
			send_item(REQ_ARRAY, $urandom_range(0, 1) ? {LEN_W{1'b1}} : {LEN_W{1'b0}});
			repeat ($urandom_range(0, 3))
				send_log($urandom_range(0, 3), data_len());
			if (stop >= MODE_ADDR)
				send_item(REQ_ARRAY, LOG_FIELDS);
			if (stop >= MODE_TOPICS)
				send_item(REQ_BYTES, ADDR_LEN);
			if (stop == MODE_TOPIC) begin
				n = $urandom_range(0, 1) ? {LEN_W{1'b1}} : LEN_W'($urandom_range(4, 1000));
				send_item(REQ_ARRAY, n);
				repeat ($urandom_range(0, 3))
					send_item(REQ_BYTES, TOPIC_LEN);
			end
			if (stop == MODE_DATA) begin
				k = $urandom_range(0, 3);
				send_item(REQ_ARRAY, LEN_W'(k));
				repeat (k)
					send_item(REQ_BYTES, TOPIC_LEN);
			end
		end
		// the offending request
		k = $urandom_range(0, 3);
		if (k == 0)
			send_item(REQ_OTHER, rand_len());
		else if (k == 1)
			send_item(REQ_DEC_ERR, rand_len());
		else begin
			case (stop)
				MODE_LOG: begin
					if (k == 2)
						send_item(REQ_ARRAY, off_size(LOG_FIELDS));
					else
						send_item(REQ_BYTES, rand_len());
				end
				MODE_ADDR: begin
					if (k == 2)
						send_item(REQ_BYTES, off_size(ADDR_LEN));
					else
						send_item(REQ_ARRAY, rand_len());
				end
				MODE_TOPIC: begin
					if (k == 2)
						send_item(REQ_BYTES, off_size(TOPIC_LEN));
					else
						send_item(REQ_ARRAY, rand_len());
				end
				MODE_DATA: send_item(REQ_ARRAY, rand_len());
				default: send_item(REQ_BYTES, rand_len());
			endcase
		end
		// everything after the failure must report the earlier failure
		repeat (40)
			send_item(req_kind_t'($urandom_range(0, 3)), rand_len());
	endtask

	// Stimulus and verdict
	initial begin
		int phase;
		int phase_end;
		int logs;
		int wait_cycles;
		item_valid <= 1'b0;
		item <= '0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty topic list, zero and maximum data length, last marks
		send_item(REQ_ARRAY, LEN_W'(2));
		send_log(0, '0);
		send_log(2, {LEN_W{1'b1}});
		send_item(REQ_ARRAY, LEN_W'(1));
		send_log(1, LEN_W'(1));

		// Random well-formed log lists, idling and stall pattern changes every phase
		phase = 0;
		phase_end = items_sent + PHASE_ITEMS;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent >= phase_end) begin
				drain();
				phase++;
				phase_end = items_sent + PHASE_ITEMS;
				case (phase % 4)
					0: begin idle_pct = 0;  stall_pct = 0;  end
					1: begin idle_pct = 70; stall_pct = 0;  end
					2: begin idle_pct = 0;  stall_pct = 70; end
					default: begin idle_pct = 37; stall_pct = 37; end
				endcase
			end
			logs = $urandom_range(0, 7) == 0 ? $urandom_range(7, 12) : $urandom_range(1, 4);
			send_item(REQ_ARRAY, LEN_W'(logs));
			repeat (logs)
				send_log($urandom_range(0, 4), data_len());
		end

		finish_with_violation();

		// Wait for the last results, with a limit
		item_valid <= 1'b0;
		wait_cycles = 0;
		@(negedge clk);
		while (pending != 0 && wait_cycles < 20000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// ===== cbor_log_schema_checker.f =====
rtl/cls_pkg.sv
rtl/cls_check.sv
rtl/cbor_log_schema_checker.sv
tb/cls_log_checker.sv
tb/testbench.sv
